// ===== rtl/unique_color_filter_core_defines.svh =====
// Assertion macros shared by the unique colour filter RTL.
`ifndef UNIQUE_COLOR_FILTER_CORE_DEFINES_SVH
`define UNIQUE_COLOR_FILTER_CORE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define UCF_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define UCF_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ucf_pkg.sv =====
// Shared constants of the unique colour filter.
package ucf_pkg;

  // Width of one input colour channel.
  localparam int unsigned CHAN_W = 8;
  // Width of one quantised output level.
  localparam int unsigned OUT_W = 7;
  // The visited bitmap is stored as bytes.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned BIT_IDX_W = 3;
  // Entries in the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

// ===== rtl/ucf_in_if.sv =====
// Pixel input channel: valid, ready and one RGB pixel.
interface ucf_in_if;
  import ucf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/ucf_out_if.sv =====
// Result channel: valid, ready and one quantised colour.
interface ucf_out_if;
  import ucf_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] red_level;
  logic [OUT_W-1:0] green_level;
  logic [OUT_W-1:0] blue_level;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  input ready);
  modport sink (input valid, input red_level, input green_level, input blue_level,
                output ready);
endinterface

// ===== rtl/ucf_front.sv =====
// Front end: accepts pixels, quantises them and forms the bitmap index.
module ucf_front #(
  parameter int unsigned LEVEL_BITS = 7
) (
  ucf_in_if.sink                 in_ch,
  input  logic                   clear_busy,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [3*LEVEL_BITS-1:0] q_wdata
);
  import ucf_pkg::*;

  logic [LEVEL_BITS-1:0] red_q;
  logic [LEVEL_BITS-1:0] green_q;
  logic [LEVEL_BITS-1:0] blue_q;

  // Quantising keeps the top LEVEL_BITS bits of each channel.
  assign red_q   = in_ch.red[CHAN_W-1 -: LEVEL_BITS];
  assign green_q = in_ch.green[CHAN_W-1 -: LEVEL_BITS];
  assign blue_q  = in_ch.blue[CHAN_W-1 -: LEVEL_BITS];

  // No item is taken while the bitmap is still being swept clear.
  assign in_ch.ready = !clear_busy && !q_full;
  assign q_push      = in_ch.valid && in_ch.ready;
  assign q_wdata     = {red_q, green_q, blue_q};
endmodule

// ===== rtl/ucf_queue.sv =====
// Short FIFO that decouples the front end from the bitmap back end.
`include "unique_color_filter_core_defines.svh"

module ucf_queue #(
  parameter int unsigned WIDTH = 21
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  import ucf_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  `UCF_ASSERT_HOLDS(a_no_push_when_full, !(push && full), "queue written while full")
  `UCF_ASSERT_HOLDS(a_no_pop_when_empty, !(pop && empty), "queue read while empty")
endmodule

// ===== rtl/ucf_back.sv =====
// Back end: visited bitmap, clearing sweep, read-modify-write and result register.
`include "unique_color_filter_core_defines.svh"

module ucf_back #(
  parameter int unsigned LEVEL_BITS = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  logic [3*LEVEL_BITS-1:0] q_rdata,
  output logic                    q_pop,
  output logic                    clear_busy,
  ucf_out_if.source               out_ch
);
  import ucf_pkg::*;

  localparam int unsigned IDX_W     = 3 * LEVEL_BITS;
  localparam int unsigned ADDR_W    = IDX_W - BIT_IDX_W;
  localparam int unsigned MAP_BYTES = 1 << ADDR_W;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } ucf_state_t;

  ucf_state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clear_addr_r, clear_addr_nxt;

  logic [BYTE_W-1:0] map_mem [MAP_BYTES];
  logic [BYTE_W-1:0] rd_data_r;

  logic              s1_valid_r, s1_valid_nxt;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [ADDR_W-1:0] s1_addr;
  logic [BIT_IDX_W-1:0] s1_bit;

  // Most recent byte written by a decision, forwarded over a stale read.
  logic              wb_valid_r;
  logic [ADDR_W-1:0] wb_addr_r;
  logic [BYTE_W-1:0] wb_data_r;

  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  red_level_r, green_level_r, blue_level_r;

  logic [BYTE_W-1:0] cur_byte;
  logic [BYTE_W-1:0] new_byte;
  logic              hit;
  logic              out_free;
  logic              retire;
  logic              miss_write;
  logic              advance;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;

  assign s1_addr  = s1_idx_r[IDX_W-1:BIT_IDX_W];
  assign s1_bit   = s1_idx_r[BIT_IDX_W-1:0];
  assign cur_byte = (wb_valid_r && (wb_addr_r == s1_addr)) ? wb_data_r : rd_data_r;
  assign hit      = cur_byte[s1_bit];
  assign new_byte = cur_byte | (BYTE_W'(1) << s1_bit);

  assign out_free   = !out_valid_r || out_ch.ready;
  assign retire     = s1_valid_r && (hit || out_free);
  assign miss_write = retire && !hit;
  assign advance    = (state_r == ST_RUN) && (!s1_valid_r || retire);
  assign q_pop      = advance && !q_empty;
  assign clear_busy = (state_r == ST_CLEAR);

  always_comb begin
    state_nxt      = state_r;
    clear_addr_nxt = clear_addr_r;
    wr_en          = 1'b0;
    wr_addr        = s1_addr;
    wr_data        = new_byte;
    case (state_r)
      ST_CLEAR: begin
        wr_en          = 1'b1;
        wr_addr        = clear_addr_r;
        wr_data        = '0;
        clear_addr_nxt = clear_addr_r + ADDR_W'(1);
        if (clear_addr_r == '1) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        wr_en = miss_write;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (advance) begin
      s1_valid_nxt = !q_empty;
    end
    out_valid_nxt = out_valid_r;
    if (miss_write) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clear_addr_r <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      wb_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clear_addr_r <= clear_addr_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (miss_write) begin
        wb_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (q_pop) begin
      rd_data_r <= map_mem[q_rdata[IDX_W-1:BIT_IDX_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_idx_r <= q_rdata;
    end
    if (miss_write) begin
      wb_addr_r     <= s1_addr;
      wb_data_r     <= new_byte;
      red_level_r   <= OUT_W'(s1_idx_r[IDX_W-1 -: LEVEL_BITS]);
      green_level_r <= OUT_W'(s1_idx_r[2*LEVEL_BITS-1 -: LEVEL_BITS]);
      blue_level_r  <= OUT_W'(s1_idx_r[LEVEL_BITS-1:0]);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.red_level   = red_level_r;
  assign out_ch.green_level = green_level_r;
  assign out_ch.blue_level  = blue_level_r;

  `UCF_ASSERT_HOLDS(a_idle_while_clearing, (state_r != ST_CLEAR) || (!s1_valid_r && !out_valid_r && !q_pop), "item in flight during clearing sweep")
  `UCF_ASSERT_NEXT(a_miss_loads_output, miss_write, out_valid_r, "new colour did not reach the result register")
  `UCF_ASSERT_NEXT(a_miss_updates_forward, miss_write, wb_valid_r && (wb_addr_r == $past(s1_addr)), "forwarded byte not updated after a new colour")
endmodule

// ===== rtl/unique_color_filter_core.sv =====
// Top level of the unique colour filter: front end, queue and bitmap back end.
// Each pixel is quantised to LEVEL_BITS bits per channel and looked up in a visited bitmap
// of 2^(3*LEVEL_BITS) bits held as bytes in one memory; the first time a colour is seen its
// bit is set and the quantised colour comes out, later pixels of that colour give nothing.
// After reset the bitmap is swept clear one byte per cycle, during which in_ch.ready stays
// low. From then on one pixel is taken every clock unless the queue is full: the bitmap
// memory does one read and one write per cycle, and the byte written last is forwarded so
// that back-to-back pixels of the same byte see it. A pixel passes through the queue, the
// s1_idx_r stage and the result register before its result appears on out_ch; a stalled
// output halts the back end at the next new colour and holds back the input once the
// two-entry queue has filled.
module unique_color_filter_core #(
  parameter int unsigned LEVEL_BITS = 7
) (
  input  logic      clk,
  input  logic      rst_n,
  ucf_in_if.sink    in_ch,
  ucf_out_if.source out_ch
);
  import ucf_pkg::*;

  localparam int unsigned IDX_W = 3 * LEVEL_BITS;

  logic             clear_busy;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  logic [IDX_W-1:0] q_wdata;
  logic [IDX_W-1:0] q_rdata;

  ucf_front #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_front (
    .in_ch      (in_ch),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  ucf_queue #(
    .WIDTH (IDX_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  ucf_back #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .out_ch     (out_ch)
  );
endmodule

// ===== test/unique_color_filter_core_tb.sv =====
// Self-checking testbench for the unique colour filter: directed table, then random pixels.
`timescale 1ns / 100ps

module unique_color_filter_core_tb;
  import ucf_pkg::*;

  localparam int unsigned LEVEL_BITS = OUT_W;
  localparam int unsigned DIRECTED_N = 24;
  localparam int unsigned PHASE_ITEMS = 180;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PALETTE_MAX = 32;
  localparam int unsigned TIMEOUT_NS = 10_000_000;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [OUT_W-1:0] red_level;
    logic [OUT_W-1:0] green_level;
    logic [OUT_W-1:0] blue_level;
  } shade_t;

  typedef struct packed {
    pixel_t pixel;
    bit     typed;
    bit     has_shade;
    shade_t shade;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ucf_in_if  in_ch ();
  ucf_out_if out_ch ();

  unique_color_filter_core #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Shades still owed by the block, oldest first.
  shade_t      owed_shades[$];
  // Predictor state: one bit per quantised colour, held as bytes.
  logic [7:0]  visited_bytes[int unsigned];
  pixel_t      recent_colours[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_out = 1'b0;

  // Rows with typed shades are read straight off the quantisation; the rest use the predictor.
  dir_row_t directed_rows [DIRECTED_N] = '{
    '{'{8'd0,   8'd0,   8'd0  }, 1'b1, 1'b1, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd1,   8'd1,   8'd1  }, 1'b1, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, 1'b1, '{7'd127, 7'd127, 7'd127}},
    '{'{8'd254, 8'd254, 8'd254}, 1'b1, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd255, 8'd0,   8'd0  }, 1'b1, 1'b1, '{7'd127, 7'd0,   7'd0  }},
    '{'{8'd0,   8'd255, 8'd0  }, 1'b1, 1'b1, '{7'd0,   7'd127, 7'd0  }},
    '{'{8'd0,   8'd0,   8'd255}, 1'b1, 1'b1, '{7'd0,   7'd0,   7'd127}},
    '{'{8'd0,   8'd0,   8'd1  }, 1'b1, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd0,   8'd0,   8'd2  }, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd0,   8'd0,   8'd4  }, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd0,   8'd0,   8'd6  }, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd0,   8'd0,   8'd7  }, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd0,   8'd0,   8'd8  }, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd0,   8'd0,   8'd10 }, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd0,   8'd0,   8'd12 }, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd0,   8'd0,   8'd14 }, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd0,   8'd0,   8'd16 }, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd0,   8'd0,   8'd17 }, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd170, 8'd85,  8'd170}, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd85,  8'd170, 8'd85 }, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd171, 8'd84,  8'd171}, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd128, 8'd128, 8'd128}, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd127, 8'd127, 8'd127}, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }},
    '{'{8'd129, 8'd129, 8'd129}, 1'b0, 1'b0, '{7'd0,   7'd0,   7'd0  }}
  };

  // Marks the pixel's quantised colour as seen; returns 1 only on its first sighting.
  function automatic bit mark_first_sighting(input pixel_t px, output shade_t shade);
    logic [3*LEVEL_BITS-1:0] colour_idx;
    int unsigned             byte_addr;
    logic [7:0]              bit_mask;
    logic [7:0]              old_byte;
    shade.red_level   = px.red[CHAN_W-1 -: LEVEL_BITS];
    shade.green_level = px.green[CHAN_W-1 -: LEVEL_BITS];
    shade.blue_level  = px.blue[CHAN_W-1 -: LEVEL_BITS];
    colour_idx = {shade.red_level, shade.green_level, shade.blue_level};
    byte_addr  = int'(colour_idx >> 3);
    bit_mask   = 8'b1 << colour_idx[2:0];
    old_byte   = visited_bytes.exists(byte_addr) ? visited_bytes[byte_addr] : 8'h00;
    if ((old_byte & bit_mask) != 8'h00) begin
      return 1'b0;
    end
    visited_bytes[byte_addr] = old_byte | bit_mask;
    return 1'b1;
  endfunction

  // Fresh colours in 40% of picks; the rest are repeats and same-byte neighbours.
  function automatic pixel_t pick_pixel();
    logic [31:0] word;
    int unsigned choice;
    pixel_t      px;
    word   = $urandom();
    choice = $urandom_range(99);
    if (choice < 40 || recent_colours.size() == 0) begin
      px = pixel_t'(word[23:0]);
      recent_colours.push_back(px);
      if (recent_colours.size() > PALETTE_MAX) begin
        void'(recent_colours.pop_front());
      end
    end else begin
      px = recent_colours[$urandom_range(recent_colours.size() - 1)];
      // The dropped low bits must not make a repeat look new.
      px.red[0]   = word[0];
      px.green[0] = word[1];
      px.blue[0]  = word[2];
      if (choice >= 75) begin
        px.blue[3:1] = word[5:3];
      end
    end
    return px;
  endfunction

  task automatic offer_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.red   <= px.red;
    in_ch.green <= px.green;
    in_ch.blue  <= px.blue;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_pixels(input int unsigned count);
    pixel_t px;
    shade_t shade;
    repeat (count) begin
      px = pick_pixel();
      offer_pixel(px);
      if (mark_first_sighting(px, shade)) begin
        owed_shades.push_back(shade);
      end
    end
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (owed_shades.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, a long hold-off on request, and the result check.
  always @(posedge clk) begin
    shade_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_shades.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %0d/%0d/%0d", $time,
                   out_ch.red_level, out_ch.green_level, out_ch.blue_level);
          mismatches++;
        end else begin
          want = owed_shades.pop_front();
          if (out_ch.red_level !== want.red_level) begin
            $display("%0t: red_level expected %0d actual %0d", $time, want.red_level,
                     out_ch.red_level);
            mismatches++;
          end
          if (out_ch.green_level !== want.green_level) begin
            $display("%0t: green_level expected %0d actual %0d", $time, want.green_level,
                     out_ch.green_level);
            mismatches++;
          end
          if (out_ch.blue_level !== want.blue_level) begin
            $display("%0t: blue_level expected %0d actual %0d", $time, want.blue_level,
                     out_ch.blue_level);
            mismatches++;
          end
        end
      end
      if (hold_out) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    shade_t shade;
    bit     fresh;
    in_ch.valid  = 1'b0;
    in_ch.red    = '0;
    in_ch.green  = '0;
    in_ch.blue   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows go back to back, so same-byte pixels meet in the pipeline.
    for (int unsigned i = 0; i < DIRECTED_N; i++) begin
      offer_pixel(directed_rows[i].pixel);
      fresh = mark_first_sighting(directed_rows[i].pixel, shade);
      if (directed_rows[i].typed) begin
        if (directed_rows[i].has_shade) begin
          owed_shades.push_back(directed_rows[i].shade);
        end
      end else if (fresh) begin
        owed_shades.push_back(shade);
      end
    end
    wait_for_drain();

    send_random_pixels(PHASE_ITEMS);
    wait_for_drain();

    send_idle_pct = 73;
    send_random_pixels(PHASE_ITEMS);
    wait_for_drain();

    send_idle_pct  = 0;
    recv_stall_pct = 73;
    send_random_pixels(PHASE_ITEMS);
    wait_for_drain();

    send_idle_pct  = 8;
    recv_stall_pct = 8;
    send_random_pixels(PHASE_ITEMS);
    wait_for_drain();

    // Receiver holds off while the sender keeps offering, so the queue fills and the input stalls.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
      end
      send_random_pixels(PHASE_ITEMS);
    join
    wait_for_drain();

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // The timeout must also leave room for the clearing sweep after reset.
  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
